/* sv/lecc_pkg.sv */
`default_nettype none
package lecc_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_EDGES    = 4096;

   localparam int VTX_W = 10;
   localparam int LBL_W = 8;
   localparam int IDX_W = $clog2(MAX_EDGES);
   localparam int CNT_W = $clog2(MAX_EDGES + 1);

   typedef logic [CNT_W-1:0] count_type;
   typedef logic [IDX_W-1:0] index_type;

   typedef struct packed {
      logic [VTX_W-1:0] src;
      logic [VTX_W-1:0] dst;
      logic [LBL_W-1:0] label;
   } edge_type;

   typedef struct packed {
      logic      rd_en;
      index_type rd_addr;
      logic      wr_en;
      index_type wr_addr;
      edge_type  wr_data;
   } mem_req_type;

   typedef struct packed {
      logic      valid;
      count_type added;
      count_type count;
      logic      overflow;
   } result_type;

   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_RULE = 1'b1;

endpackage
`default_nettype wire

/* sv/lecc_store.sv */
`default_nettype none
module lecc_store (
   input  wire logic                 clock,
   input  wire lecc_pkg::mem_req_type mem_req,
   output lecc_pkg::edge_type        rd_data
);
   import lecc_pkg::*;

   edge_type mem [MAX_EDGES];
   edge_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/lecc_seq.sv */
`default_nettype none
module lecc_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  func,
   input  wire lecc_pkg::edge_type    add_edge,
   input  wire logic [7:0]            first_label,
   input  wire logic [7:0]            second_label,
   input  wire logic [7:0]            new_label,
   input  wire logic                  out_free,
   input  wire lecc_pkg::edge_type    rd_data,
   output logic                       idle,
   output lecc_pkg::mem_req_type      mem_req,
   output lecc_pkg::result_type       result
);
   import lecc_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b0_0000_0001,
      S_A_NEXT = 9'b0_0000_0010,
      S_A_CHK  = 9'b0_0000_0100,
      S_B_NEXT = 9'b0_0000_1000,
      S_B_CHK  = 9'b0_0001_0000,
      S_D_NEXT = 9'b0_0010_0000,
      S_D_CHK  = 9'b0_0100_0000,
      S_INS    = 9'b0_1000_0000,
      S_DONE   = 9'b1_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   count_type  a_ff, a_in, b_ff, b_in, k_ff, k_in;
   count_type  count_ff, count_in, added_ff, added_in;
   logic       ovf_ff, ovf_in, is_rule_ff, is_rule_in;
   edge_type   ea_ff, ea_in, cand_ff, cand_in;
   logic [LBL_W-1:0] f1_ff, f1_in, f2_ff, f2_in, nl_ff, nl_in;
   logic       vtx_ok;

   assign vtx_ok = (32'(add_edge.src) < 32'(MAX_VERTICES)) &&
                   (32'(add_edge.dst) < 32'(MAX_VERTICES));

   always_comb begin
      state_in   = state_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      count_in   = count_ff;
      added_in   = added_ff;
      ovf_in     = ovf_ff;
      is_rule_in = is_rule_ff;
      ea_in      = ea_ff;
      cand_in    = cand_ff;
      f1_in      = f1_ff;
      f2_in      = f2_ff;
      nl_in      = nl_ff;
      mem_req    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               added_in = '0;
               ovf_in   = 1'b0;
               k_in     = '0;
               a_in     = '0;
               f1_in    = first_label;
               f2_in    = second_label;
               nl_in    = new_label;
               cand_in  = add_edge;
               if (func == FUNC_RULE) begin
                  is_rule_in = 1'b1;
                  state_in   = S_A_NEXT;
               end else begin
                  is_rule_in = 1'b0;
                  state_in   = vtx_ok ? S_D_NEXT : S_DONE;
               end
            end
         end
         S_A_NEXT: begin
            if (a_ff < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = a_ff[IDX_W-1:0];
               state_in        = S_A_CHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_A_CHK: begin
            ea_in = rd_data;
            if (rd_data.label == f1_ff) begin
               b_in     = '0;
               state_in = S_B_NEXT;
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = S_A_NEXT;
            end
         end
         S_B_NEXT: begin
            if (b_ff < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = b_ff[IDX_W-1:0];
               state_in        = S_B_CHK;
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = S_A_NEXT;
            end
         end
         S_B_CHK: begin
            if (rd_data.label == f2_ff && ea_ff.dst == rd_data.src) begin
               cand_in.src   = ea_ff.src;
               cand_in.dst   = rd_data.dst;
               cand_in.label = nl_ff;
               k_in          = '0;
               state_in      = S_D_NEXT;
            end else begin
               b_in     = b_ff + 1'b1;
               state_in = S_B_NEXT;
            end
         end
         S_D_NEXT: begin
            if (k_ff < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = k_ff[IDX_W-1:0];
               state_in        = S_D_CHK;
            end else begin
               state_in = S_INS;
            end
         end
         S_D_CHK: begin
            if (rd_data == cand_ff) begin
               // duplicate: resume the caller
               if (is_rule_ff) begin
                  b_in     = b_ff + 1'b1;
                  state_in = S_B_NEXT;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_D_NEXT;
            end
         end
         S_INS: begin
            if (count_ff >= CNT_W'(MAX_EDGES)) begin
               ovf_in = 1'b1;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = count_ff[IDX_W-1:0];
               mem_req.wr_data = cand_ff;
               count_in        = count_ff + 1'b1;
               added_in        = added_ff + 1'b1;
            end
            if (is_rule_ff) begin
               b_in     = b_ff + 1'b1;
               state_in = S_B_NEXT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      k_ff       <= k_in;
      added_ff   <= added_in;
      ovf_ff     <= ovf_in;
      is_rule_ff <= is_rule_in;
      ea_ff      <= ea_in;
      cand_ff    <= cand_in;
      f1_ff      <= f1_in;
      f2_ff      <= f2_in;
      nl_ff      <= nl_in;
   end

   assign idle            = (state_ff == S_IDLE);
   assign result.valid    = (state_ff == S_DONE);
   assign result.added    = added_ff;
   assign result.count    = count_ff;
   assign result.overflow = ovf_ff;

endmodule
`default_nettype wire

/* sv/labeled_edge_composition_closure.sv */
// operation: an add request reads every stored edge to find a duplicate before it inserts;
//   a rule request reads the stored edges as outer edges, scans the whole table as inner
//   edges for each outer edge carrying the first label, and runs the duplicate scan per shortcut candidate
// flow control: one request at a time, accepted only while the sequencer is idle, which it re-enters
//   when the previous response is loaded; a stalled response holds the sequencer until it is taken
// reset clears the edge count and the sequencer; table contents are left as they are
`default_nettype none
module labeled_edge_composition_closure (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [9:0]  req_src_vertex,
   input  wire logic [9:0]  req_dst_vertex,
   input  wire logic [7:0]  req_edge_label,
   input  wire logic [7:0]  req_first_label,
   input  wire logic [7:0]  req_second_label,
   input  wire logic [7:0]  req_new_label,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [12:0]      rsp_edges_added,
   output logic [12:0]      rsp_edge_count,
   output logic             rsp_overflow
);
   import lecc_pkg::*;

   logic        idle;
   logic        out_free;
   edge_type    add_edge;
   edge_type    rd_data;
   mem_req_type mem_req;
   result_type  result;

   logic        rsp_valid_ff, rsp_valid_in;
   count_type   rsp_added_ff, rsp_added_in, rsp_count_ff, rsp_count_in;
   logic        rsp_ovf_ff, rsp_ovf_in;

   assign add_edge.src   = req_src_vertex;
   assign add_edge.dst   = req_dst_vertex;
   assign add_edge.label = req_edge_label;
   assign req_stall      = !idle;
   assign out_free       = !rsp_valid_ff || !rsp_stall;

   lecc_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (req_valid),
      .func         (req_func),
      .add_edge     (add_edge),
      .first_label  (req_first_label),
      .second_label (req_second_label),
      .new_label    (req_new_label),
      .out_free     (out_free),
      .rd_data      (rd_data),
      .idle         (idle),
      .mem_req      (mem_req),
      .result       (result)
   );

   lecc_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // output register holding a finished request
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_added_in = rsp_added_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (result.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_added_in = result.added;
         rsp_count_in = result.count;
         rsp_ovf_in   = result.overflow;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_added_ff <= rsp_added_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_edges_added = rsp_added_ff;
   assign rsp_edge_count  = rsp_count_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule
`default_nettype wire
